### hw/rtl/rpvs_pkg.sv
// ----------------------------------------------------------------------------
// rpvs_pkg
// Shared types, codes and saturation helpers for the rational function
// value and slope unit.
// ----------------------------------------------------------------------------
package rpvs_pkg;

   localparam int DEF_MAX_NUM_TERMS = 7;
   localparam int DEF_MAX_DEN_TERMS = 7;
   localparam int VAL_W      = 48;
   localparam int COEF_W     = 32;
   localparam int X_W        = 24;
   localparam int SLOT_W     = 4;
   localparam int TERM_W     = 3;
   localparam int WEIGHT_W   = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic signed [47:0] SAT_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] SAT_MIN = 48'sh8000_0000_0000;
   localparam logic signed [47:0] ONE_Q16 = 48'sd65536;
   localparam logic [23:0] SCALE_RESET = 24'd65536;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   typedef enum logic [1:0] {
      CSR_NUM_TERMS   = 2'd0,
      CSR_DEN_TERMS   = 2'd1,
      CSR_INPUT_SCALE = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PASS_N  = 2'd0,
      PASS_NP = 2'd1,
      PASS_D  = 2'd2,
      PASS_DP = 2'd3
   } pass_type;

   typedef enum logic [1:0] {
      MA_ACC = 2'd0,
      MA_NP  = 2'd1,
      MA_N   = 2'd2
   } mul_a_type;

   typedef enum logic [1:0] {
      MB_XS = 2'd0,
      MB_D  = 2'd1,
      MB_DP = 2'd2
   } mul_b_type;

   typedef enum logic [1:0] {
      DA_N   = 2'd0,
      DA_TOP = 2'd1,
      DA_TMP = 2'd2
   } div_a_type;

   typedef enum logic [1:0] {
      DD_FIT   = 2'd0,
      DD_TMP   = 2'd1,
      DD_SLOPE = 2'd2
   } div_dest_type;

   typedef struct packed {
      logic                tbl_write;
      logic                x_load;
      logic                acc_init;
      logic                acc_add_coef;
      logic                acc_add_one;
      logic                acc_load_mul;
      logic                top_sub;
      logic                store;
      pass_type            dest;
      logic                mul_start;
      mul_a_type           mul_a;
      mul_b_type           mul_b;
      logic                div_start;
      div_a_type           div_a;
      logic                div_load;
      div_dest_type        div_dest;
      logic                zero_fill;
      logic                out_load;
      logic [WEIGHT_W-1:0] weight;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic d_zero;
   } dp_status_type;

   function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
      if (v[49:47] != {3{v[49]}}) begin
         return v[49] ? SAT_MIN : SAT_MAX;
      end
      return v[47:0];
   endfunction

   function automatic logic signed [47:0] apply_sign(input logic [80:0] m, input logic neg);
      logic ovf;
      ovf = (|m[80:48]) || (m[47] && (!neg || (|m[46:0])));
      if (ovf) begin
         return neg ? SAT_MIN : SAT_MAX;
      end
      return neg ? $signed(48'(~m[47:0] + 48'd1)) : $signed(m[47:0]);
   endfunction

   function automatic logic [47:0] mag48(input logic signed [47:0] v);
      return v[47] ? 48'(~v + 48'sd1) : v;
   endfunction

endpackage

### hw/rtl/rpvs_mul.sv
// ----------------------------------------------------------------------------
// rpvs_mul
// Saturating Q.16 multiplier: 48x16 partial product per cycle, three digits.
// ----------------------------------------------------------------------------
module rpvs_mul
   import rpvs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [47:0] op_a,
   input  logic signed [47:0] op_b,
   output logic               done,
   output logic signed [47:0] result
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [1:0]  step_ff, step_in;
   logic [47:0] ma_ff;
   logic [47:0] mb_ff;
   logic        neg_ff;
   logic [48:0] hi_ff;
   logic [31:0] lo_ff;
   logic signed [47:0] res_ff;
   logic [63:0] prod;
   logic [64:0] sum;

   assign prod = ma_ff * mb_ff[15:0];
   assign sum  = {16'd0, hi_ff} + {1'b0, prod};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 2'd0;
      end else if (busy_ff) begin
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ma_ff  <= mag48(op_a);
         mb_ff  <= mag48(op_b);
         neg_ff <= op_a[47] ^ op_b[47];
         hi_ff  <= '0;
         lo_ff  <= '0;
      end else if (busy_ff) begin
         if (step_ff == 2'd3) begin
            res_ff <= apply_sign({hi_ff, lo_ff}, neg_ff);
         end else begin
            hi_ff <= sum[64:16];
            lo_ff <= {sum[15:0], lo_ff[31:16]};
            mb_ff <= {16'd0, mb_ff[47:16]};
         end
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

### hw/rtl/rpvs_div.sv
// ----------------------------------------------------------------------------
// rpvs_div
// Saturating Q.16 divider: restoring radix-2, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpvs_div
   import rpvs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [47:0] op_a,
   input  logic signed [47:0] op_b,
   output logic               done,
   output logic signed [47:0] result
);

   logic        busy_ff, busy_in;
   logic        fin_ff, fin_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] dq_ff;
   logic [47:0] rem_ff;
   logic [47:0] dv_ff;
   logic        neg_ff;
   logic signed [47:0] res_ff;
   logic [48:0] rsh;
   logic        ge;

   assign rsh = {rem_ff, dq_ff[63]};
   assign ge  = rsh >= {1'b0, dv_ff};

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd63;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff  <= {mag48(op_a), 16'd0};
         dv_ff  <= mag48(op_b);
         rem_ff <= '0;
         neg_ff <= op_a[47] ^ op_b[47];
      end else if (busy_ff) begin
         rem_ff <= ge ? 48'(rsh - {1'b0, dv_ff}) : rsh[47:0];
         dq_ff  <= {dq_ff[62:0], ge};
      end else if (fin_ff) begin
         res_ff <= apply_sign({17'd0, dq_ff}, neg_ff);
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

### hw/rtl/rpvs_datapath.sv
// ----------------------------------------------------------------------------
// rpvs_datapath
// Coefficient table, Horner accumulator, operand registers and result
// register; owns the shared multiplier and divider.
// ----------------------------------------------------------------------------
module rpvs_datapath
   import rpvs_pkg::*;
#(
   parameter int MAX_NUMERATOR_TERMS   = DEF_MAX_NUM_TERMS,
   parameter int MAX_DENOMINATOR_TERMS = DEF_MAX_DEN_TERMS,
   localparam int DEPTH  = MAX_NUMERATOR_TERMS + MAX_DENOMINATOR_TERMS,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   input  logic [ADDR_W-1:0]   coef_addr,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic signed [COEF_W-1:0] req_coef,
   input  logic [X_W-1:0]      req_x,
   input  logic [X_W-1:0]      input_scale,
   output dp_status_type       status,
   output logic signed [VAL_W-1:0] fit_value,
   output logic signed [VAL_W-1:0] slope_value,
   output logic                zero_denominator
);

   logic signed [COEF_W-1:0] tbl_ff [DEPTH];
   logic [31:0]        xs_ff;
   logic signed [47:0] acc_ff, n_ff, np_ff, d_ff, dp_ff, top_ff, tmp_ff;
   logic signed [47:0] fit_ff, slope_ff;
   logic               zero_ff;
   logic signed [47:0] rsp_fit_ff, rsp_slope_ff;
   logic               rsp_zero_ff;

   logic signed [COEF_W-1:0] coef;
   logic signed [37:0] cw;
   logic [47:0]        xprod;
   logic signed [47:0] mul_a, mul_b, mul_res, div_a, div_res;
   logic               mul_done, div_done;

   assign coef  = tbl_ff[coef_addr];
   assign cw    = 38'(coef) * 38'($signed({1'b0, cmd.weight}));
   assign xprod = req_x * input_scale;

   always_comb begin
      unique case (cmd.mul_a)
         MA_ACC:  mul_a = acc_ff;
         MA_NP:   mul_a = np_ff;
         MA_N:    mul_a = n_ff;
         default: mul_a = acc_ff;
      endcase
      unique case (cmd.mul_b)
         MB_XS:   mul_b = $signed({16'd0, xs_ff});
         MB_D:    mul_b = d_ff;
         MB_DP:   mul_b = dp_ff;
         default: mul_b = $signed({16'd0, xs_ff});
      endcase
      unique case (cmd.div_a)
         DA_N:    div_a = n_ff;
         DA_TOP:  div_a = top_ff;
         DA_TMP:  div_a = tmp_ff;
         default: div_a = n_ff;
      endcase
   end

   rpvs_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   rpvs_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.div_start),
      .op_a   (div_a),
      .op_b   (d_ff),
      .done   (div_done),
      .result (div_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            tbl_ff[i] <= '0;
         end
      end else if (cmd.tbl_write) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (int'(req_slot) == i) begin
               tbl_ff[i] <= req_coef;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.x_load) begin
         xs_ff   <= xprod[47:16];
         np_ff   <= '0;
         d_ff    <= ONE_Q16;
         dp_ff   <= '0;
         zero_ff <= 1'b0;
      end
      priority if (cmd.acc_init) begin
         acc_ff <= 48'(cw);
      end else if (cmd.acc_add_coef) begin
         acc_ff <= sat48(50'(mul_res) + 50'(cw));
      end else if (cmd.acc_add_one) begin
         acc_ff <= sat48(50'(mul_res) + 50'(ONE_Q16));
      end else if (cmd.acc_load_mul) begin
         acc_ff <= mul_res;
      end
      if (cmd.top_sub) begin
         top_ff <= sat48(50'(acc_ff) - 50'(mul_res));
      end
      if (cmd.store) begin
         unique case (cmd.dest)
            PASS_N:  n_ff  <= acc_ff;
            PASS_NP: np_ff <= acc_ff;
            PASS_D:  d_ff  <= acc_ff;
            PASS_DP: dp_ff <= acc_ff;
         endcase
      end
      if (cmd.div_load) begin
         unique case (cmd.div_dest)
            DD_FIT:   fit_ff   <= div_res;
            DD_TMP:   tmp_ff   <= div_res;
            DD_SLOPE: slope_ff <= div_res;
            default:  tmp_ff   <= div_res;
         endcase
      end
      if (cmd.zero_fill) begin
         fit_ff   <= n_ff[47] ? SAT_MIN : SAT_MAX;
         slope_ff <= top_ff[47] ? SAT_MIN : SAT_MAX;
         zero_ff  <= 1'b1;
      end
      if (cmd.out_load) begin
         rsp_fit_ff   <= fit_ff;
         rsp_slope_ff <= slope_ff;
         rsp_zero_ff  <= zero_ff;
      end
   end

   assign status.mul_done = mul_done;
   assign status.div_done = div_done;
   assign status.d_zero   = (d_ff == 48'sd0);

   assign fit_value        = rsp_fit_ff;
   assign slope_value      = rsp_slope_ff;
   assign zero_denominator = rsp_zero_ff;

endmodule

### hw/rtl/rpvs_ctrl.sv
// ----------------------------------------------------------------------------
// rpvs_ctrl
// Sequencer: Horner passes, numerator of the slope, three divisions (skipped
// for a zero denominator) and the result handshake.
// ----------------------------------------------------------------------------
module rpvs_ctrl
   import rpvs_pkg::*;
#(
   parameter int MAX_NUMERATOR_TERMS   = DEF_MAX_NUM_TERMS,
   parameter int MAX_DENOMINATOR_TERMS = DEF_MAX_DEN_TERMS,
   localparam int DEPTH  = MAX_NUMERATOR_TERMS + MAX_DENOMINATOR_TERMS,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int MAXT   = (MAX_NUMERATOR_TERMS > MAX_DENOMINATOR_TERMS) ?
                           MAX_NUMERATOR_TERMS : MAX_DENOMINATOR_TERMS,
   localparam int CNT_W  = (MAXT > 1) ? $clog2(MAXT) : 1
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_op,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [TERM_W-1:0] num_terms,
   input  logic [TERM_W-1:0] den_terms,
   input  dp_status_type     status,
   output dp_cmd_type        cmd,
   output logic [ADDR_W-1:0] coef_addr
);

   typedef enum logic [11:0] {
      S_IDLE     = 12'b0000_0000_0001,
      S_INIT     = 12'b0000_0000_0010,
      S_MUL_GO   = 12'b0000_0000_0100,
      S_MUL_WAIT = 12'b0000_0000_1000,
      S_STORE    = 12'b0000_0001_0000,
      S_TOP_M1   = 12'b0000_0010_0000,
      S_TOP_W1   = 12'b0000_0100_0000,
      S_TOP_M2   = 12'b0000_1000_0000,
      S_TOP_W2   = 12'b0001_0000_0000,
      S_DIV_GO   = 12'b0010_0000_0000,
      S_DIV_WAIT = 12'b0100_0000_0000,
      S_FINISH   = 12'b1000_0000_0000
   } state_type;

   state_type        state_ff, state_in;
   pass_type         pass_ff, pass_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       dstep_ff, dstep_in;
   logic             rsp_valid_ff, rsp_valid_in;

   int               nt_i, dt_i, lo_i;
   logic [CNT_W-1:0] nt_top, dt_top, idx;
   logic             accept;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      nt_i = (num_terms == '0) ? 1 : int'(num_terms);
      if (nt_i > MAX_NUMERATOR_TERMS) nt_i = MAX_NUMERATOR_TERMS;
      dt_i = int'(den_terms);
      if (dt_i > MAX_DENOMINATOR_TERMS) dt_i = MAX_DENOMINATOR_TERMS;
   end

   assign nt_top = CNT_W'(nt_i - 1);
   assign dt_top = (dt_i > 0) ? CNT_W'(dt_i - 1) : '0;
   assign lo_i   = (pass_ff == PASS_NP) ? 1 : 0;
   assign idx    = (state_ff == S_MUL_WAIT) ? CNT_W'(cnt_ff - 1'b1) : cnt_ff;

   always_comb begin
      if (pass_ff == PASS_D || pass_ff == PASS_DP) begin
         coef_addr = ADDR_W'(MAX_NUMERATOR_TERMS + int'(idx));
      end else begin
         coef_addr = ADDR_W'(idx);
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.dest     = pass_ff;
      cmd.mul_a    = MA_ACC;
      cmd.mul_b    = MB_XS;
      cmd.div_a    = DA_N;
      cmd.div_dest = DD_FIT;
      unique case (pass_ff)
         PASS_NP: cmd.weight = WEIGHT_W'(idx);
         PASS_DP: cmd.weight = WEIGHT_W'(int'(idx) + 1);
         default: cmd.weight = WEIGHT_W'(1);
      endcase
      unique case (dstep_ff)
         2'd0: begin
            cmd.div_a    = DA_N;
            cmd.div_dest = DD_FIT;
         end
         2'd1: begin
            cmd.div_a    = DA_TOP;
            cmd.div_dest = DD_TMP;
         end
         default: begin
            cmd.div_a    = DA_TMP;
            cmd.div_dest = DD_SLOPE;
         end
      endcase

      state_in     = state_ff;
      pass_in      = pass_ff;
      cnt_in       = cnt_ff;
      dstep_in     = dstep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_op == OP_WRITE) begin
                  cmd.tbl_write = 1'b1;
               end else begin
                  cmd.x_load = 1'b1;
                  pass_in    = PASS_N;
                  cnt_in     = nt_top;
                  state_in   = S_INIT;
               end
            end
         end
         S_INIT: begin
            cmd.acc_init = 1'b1;
            if (int'(cnt_ff) > lo_i || pass_ff == PASS_D) state_in = S_MUL_GO;
            else state_in = S_STORE;
         end
         S_MUL_GO: begin
            cmd.mul_start = 1'b1;
            state_in      = S_MUL_WAIT;
         end
         S_MUL_WAIT: begin
            if (status.mul_done) begin
               if (pass_ff == PASS_D && cnt_ff == '0) begin
                  cmd.acc_add_one = 1'b1;
                  state_in        = S_STORE;
               end else begin
                  cmd.acc_add_coef = 1'b1;
                  cnt_in           = idx;
                  if (int'(cnt_ff) - 1 > lo_i || pass_ff == PASS_D) state_in = S_MUL_GO;
                  else state_in = S_STORE;
               end
            end
         end
         S_STORE: begin
            cmd.store = 1'b1;
            unique case (pass_ff)
               PASS_N: begin
                  if (nt_i > 1) begin
                     pass_in  = PASS_NP;
                     cnt_in   = nt_top;
                     state_in = S_INIT;
                  end else if (dt_i > 0) begin
                     pass_in  = PASS_D;
                     cnt_in   = dt_top;
                     state_in = S_INIT;
                  end else begin
                     state_in = S_TOP_M1;
                  end
               end
               PASS_NP: begin
                  if (dt_i > 0) begin
                     pass_in  = PASS_D;
                     cnt_in   = dt_top;
                     state_in = S_INIT;
                  end else begin
                     state_in = S_TOP_M1;
                  end
               end
               PASS_D: begin
                  pass_in  = PASS_DP;
                  cnt_in   = dt_top;
                  state_in = S_INIT;
               end
               PASS_DP: state_in = S_TOP_M1;
            endcase
         end
         S_TOP_M1: begin
            cmd.mul_start = 1'b1;
            cmd.mul_a     = MA_NP;
            cmd.mul_b     = MB_D;
            state_in      = S_TOP_W1;
         end
         S_TOP_W1: begin
            if (status.mul_done) begin
               cmd.acc_load_mul = 1'b1;
               state_in         = S_TOP_M2;
            end
         end
         S_TOP_M2: begin
            cmd.mul_start = 1'b1;
            cmd.mul_a     = MA_N;
            cmd.mul_b     = MB_DP;
            state_in      = S_TOP_W2;
         end
         S_TOP_W2: begin
            if (status.mul_done) begin
               cmd.top_sub = 1'b1;
               dstep_in    = 2'd0;
               state_in    = S_DIV_GO;
            end
         end
         S_DIV_GO: begin
            if (status.d_zero) begin
               cmd.zero_fill = 1'b1;
               state_in      = S_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.div_load = 1'b1;
               if (dstep_ff == 2'd2) begin
                  state_in = S_FINISH;
               end else begin
                  dstep_in = dstep_ff + 2'd1;
                  state_in = S_DIV_GO;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pass_ff      <= PASS_N;
         cnt_ff       <= '0;
         dstep_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         cnt_ff       <= cnt_in;
         dstep_ff     <= dstep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hw/rtl/rational_polynomial_value_and_slope.sv
// ----------------------------------------------------------------------------
// rational_polynomial_value_and_slope
// Rational function N(x)/(1+D(x)) and its slope, saturated Q32.16.
//
//   channel | dir | handshake               | payload
//   req     | in  | req_tvalid/req_tready   | tuser operation, tdata slot/coef/x
//   rsp     | out | rsp_tvalid/rsp_tready   | tdata fit/slope, tuser zero flag
//   csr     | in  | csr_valid/csr_ready     | csr_index, csr_data
//
// A coefficient write is taken in the idle state and returns no result. An
// evaluation runs its multiplies on the shared 48x16 multiplier (up to 24
// Horner steps plus two for the slope numerator), then three serial divisions;
// a zero denominator skips the divisions.
// Reset clears the coefficient table and loads the register defaults at once.
// A waiting result stalls only the end of the next evaluation.
// ----------------------------------------------------------------------------
module rational_polynomial_value_and_slope
   import rpvs_pkg::*;
#(
   parameter int MAX_NUMERATOR_TERMS   = DEF_MAX_NUM_TERMS,
   parameter int MAX_DENOMINATOR_TERMS = DEF_MAX_DEN_TERMS
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [63:0]           req_tdata,  // coef_slot, coef_word, x_value, pad
   input  logic                  req_tuser,  // operation
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [95:0]           rsp_tdata,  // fit_value, slope_value
   output logic                  rsp_tuser,  // zero_denominator
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int DEPTH  = MAX_NUMERATOR_TERMS + MAX_DENOMINATOR_TERMS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [TERM_W-1:0] num_terms_ff, den_terms_ff;
   logic [X_W-1:0]    scale_ff;
   dp_cmd_type        cmd;
   dp_status_type     status;
   logic [ADDR_W-1:0] coef_addr;
   logic signed [VAL_W-1:0] fit_value, slope_value;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_terms_ff <= TERM_W'(1);
         den_terms_ff <= '0;
         scale_ff     <= SCALE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NUM_TERMS:   num_terms_ff <= csr_data[TERM_W-1:0];
            CSR_DEN_TERMS:   den_terms_ff <= csr_data[TERM_W-1:0];
            CSR_INPUT_SCALE: scale_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   rpvs_ctrl #(
      .MAX_NUMERATOR_TERMS   (MAX_NUMERATOR_TERMS),
      .MAX_DENOMINATOR_TERMS (MAX_DENOMINATOR_TERMS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .num_terms  (num_terms_ff),
      .den_terms  (den_terms_ff),
      .status     (status),
      .cmd        (cmd),
      .coef_addr  (coef_addr)
   );

   rpvs_datapath #(
      .MAX_NUMERATOR_TERMS   (MAX_NUMERATOR_TERMS),
      .MAX_DENOMINATOR_TERMS (MAX_DENOMINATOR_TERMS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .coef_addr        (coef_addr),
      .req_slot         (req_tdata[3:0]),
      .req_coef         ($signed(req_tdata[35:4])),
      .req_x            (req_tdata[59:36]),
      .input_scale      (scale_ff),
      .status           (status),
      .fit_value        (fit_value),
      .slope_value      (slope_value),
      .zero_denominator (rsp_tuser)
   );

   assign rsp_tdata = {slope_value, fit_value};

endmodule

### hw/rtl/rpvs_checker.sv
// ----------------------------------------------------------------------------
// rpvs_checker
// Port-level checks for the rational function unit, bound to the top level.
// ----------------------------------------------------------------------------
module rpvs_checker
   import rpvs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [95:0]           rsp_tdata,
   input logic                  rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_zero_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (rsp_tdata[47:0] == SAT_MAX || rsp_tdata[47:0] == SAT_MIN) &&
         (rsp_tdata[95:48] == SAT_MAX || rsp_tdata[95:48] == SAT_MIN))
      else $error("zero denominator without saturated outputs");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_WRITE && !rsp_tvalid |=> !rsp_tvalid)
      else $error("coefficient write produced a result");

   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_EVAL |=> !req_tready)
      else $error("input taken during evaluation");

endmodule

bind rational_polynomial_value_and_slope rpvs_checker u_rpvs_checker (.*);

### bench/rpvs_checker.sv
// ----------------------------------------------------------------------------
// rpvs_scoreboard
// Watches the request, response and register channels of the rational
// function unit, predicts value, slope and zero flag for every accepted
// evaluate transaction, and compares each accepted response in order.
// ----------------------------------------------------------------------------
module rpvs_scoreboard
   import rpvs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [63:0]           req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [95:0]           rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    errors,
   output int                    outstanding
);

   localparam int TBL_DEPTH = DEF_MAX_NUM_TERMS + DEF_MAX_DEN_TERMS;
   localparam longint Q_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint Q_MIN = -Q_MAX - 1;
   localparam longint Q_ONE = 65536;

   typedef struct {
      logic [47:0] fit;
      logic [47:0] slope;
      logic        zero;
   } eval_result_type;

   longint          coef_tbl [TBL_DEPTH];
   logic [2:0]      num_terms;
   logic [2:0]      den_terms;
   logic [23:0]     x_scale;
   eval_result_type expected_results [$];

   function automatic longint q_clamp(input longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
   endfunction

   function automatic logic [127:0] q_mag(input longint v);
      longint unsigned m;
      m = (v < 0) ? -v : v;
      return {64'd0, m};
   endfunction

   function automatic longint q_signed(input logic [127:0] m, input logic neg);
      logic [127:0] lim;
      lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
      if (m > lim) m = lim;
      return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
   endfunction

   function automatic longint q_mul(input longint a, input longint b);
      return q_signed((q_mag(a) * q_mag(b)) >> 16, (a < 0) != (b < 0));
   endfunction

   function automatic longint q_div(input longint a, input longint b);
      return q_signed((q_mag(a) << 16) / q_mag(b), (a < 0) != (b < 0));
   endfunction

   function automatic longint horner_value(input int base, input int count, input longint xs);
      longint acc;
      acc = coef_tbl[base + count - 1];
      for (int i = count - 2; i >= 0; i--)
         acc = q_clamp(q_mul(acc, xs) + coef_tbl[base + i]);
      return acc;
   endfunction

   function automatic longint horner_slope(input int base, input int count, input int off,
                                           input longint xs);
      longint acc;
      acc = coef_tbl[base + count - 1] * (count - 1 + off);
      for (int i = count - 2; i >= 0; i--) begin
         if (i + off == 0) break;
         acc = q_clamp(q_mul(acc, xs) + q_clamp(coef_tbl[base + i] * (i + off)));
      end
      return q_clamp(acc);
   endfunction

   function automatic eval_result_type predict_eval(input logic [23:0] x);
      eval_result_type r;
      int     nt, dt;
      longint xs, n, np, d, dp, top;
      nt = (num_terms == 0) ? 1 : num_terms;
      dt = den_terms;
      xs = longint'({40'd0, x} * {40'd0, x_scale}) >>> 16;
      n  = horner_value(0, nt, xs);
      np = (nt > 1) ? horner_slope(0, nt, 0, xs) : 0;
      if (dt > 0) begin
         d  = q_clamp(q_mul(horner_value(DEF_MAX_NUM_TERMS, dt, xs), xs) + Q_ONE);
         dp = horner_slope(DEF_MAX_NUM_TERMS, dt, 1, xs);
      end else begin
         d  = Q_ONE;
         dp = 0;
      end
      top = q_clamp(q_mul(np, d) - q_mul(n, dp));
      if (d == 0) begin
         r.zero  = 1'b1;
         r.fit   = (n < 0) ? SAT_MIN : SAT_MAX;
         r.slope = (top < 0) ? SAT_MIN : SAT_MAX;
      end else begin
         r.zero  = 1'b0;
         r.fit   = 48'(q_div(n, d));
         r.slope = 48'(q_div(q_div(top, d), d));
      end
      return r;
   endfunction

   always @(posedge clock) begin
      eval_result_type e;
      if (reset) begin
         foreach (coef_tbl[i]) coef_tbl[i] = 0;
         num_terms = 3'd1;
         den_terms = 3'd0;
         x_scale   = SCALE_RESET;
         expected_results.delete();
         errors    = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_NUM_TERMS:   num_terms = csr_data[2:0];
               CSR_DEN_TERMS:   den_terms = csr_data[2:0];
               CSR_INPUT_SCALE: x_scale   = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_WRITE) begin
               if (req_tdata[3:0] < TBL_DEPTH)
                  coef_tbl[req_tdata[3:0]] = longint'($signed(req_tdata[35:4]));
            end else begin
               expected_results = {expected_results, predict_eval(req_tdata[59:36])};
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected response transaction");
               errors++;
            end else begin
               e = expected_results.pop_front();
               if (rsp_tdata[47:0] !== e.fit) begin
                  $error("fit_value expected %h actual %h", e.fit, rsp_tdata[47:0]);
                  errors++;
               end
               if (rsp_tdata[95:48] !== e.slope) begin
                  $error("slope_value expected %h actual %h", e.slope, rsp_tdata[95:48]);
                  errors++;
               end
               if (rsp_tuser !== e.zero) begin
                  $error("zero_denominator expected %b actual %b", e.zero, rsp_tuser);
                  errors++;
               end
            end
         end
      end
      outstanding = expected_results.size();
   end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives coefficient writes and evaluations into the rational function unit
// under changing term counts and input scales, with bursty input, a
// patterned output stall and one long output hold-off; the scoreboard
// predicts and compares every response.
// ----------------------------------------------------------------------------
module tb
   import rpvs_pkg::*;
();

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [63:0]           req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [95:0]           rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    errors;
   int                    outstanding;
   int                    sent;
   int                    burst_left;
   logic                  hold_off;

   rational_polynomial_value_and_slope dut (.*);

   rpvs_scoreboard u_scoreboard (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      hold_off = 1'b0;
      wait (sent >= 300);
      hold_off = 1'b1;
      repeat (4000) @(posedge clock);
      hold_off = 1'b0;
   end

   always @(posedge clock) begin
      int mode;
      mode = ($time / 640) % 3;
      if (reset || hold_off) rsp_tready <= 1'b0;
      else if (mode == 0)    rsp_tready <= 1'b1;
      else if (mode == 1)    rsp_tready <= ($urandom_range(0, 1) == 1);
      else                   rsp_tready <= ($urandom_range(0, 9) == 0);
   end

   task automatic send(input logic op, input logic [3:0] slot, input logic [31:0] word,
                       input logic [23:0] x);
      req_tuser  <= op;
      req_tdata  <= {4'd0, x, word, slot};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      if (--burst_left <= 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 8);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (500) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [23:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [2:0] nt, input logic [2:0] dt, input logic [23:0] sc);
      wait_idle();
      write_csr(CSR_NUM_TERMS, {21'd0, nt});
      write_csr(CSR_DEN_TERMS, {21'd0, dt});
      write_csr(CSR_INPUT_SCALE, sc);
   endtask

   task automatic random_item();
      logic        op;
      logic [3:0]  slot;
      logic [31:0] word;
      logic [23:0] x;
      op   = ($urandom_range(0, 2) == 0) ? OP_WRITE : OP_EVAL;
      slot = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(14, 15))
                                          : 4'($urandom_range(0, 13));
      word = ($urandom_range(0, 3) == 0) ? $urandom
                                         : 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
      x    = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 24'h2_FFFF));
      send(op, slot, word, x);
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_WRITE;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_NUM_TERMS;
      csr_data   <= '0;
      sent       = 0;
      burst_left = 4;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(OP_EVAL, 4'd0, 32'd0, 24'd0);
      send(OP_WRITE, 4'd0, 32'h7FFF_FFFF, 24'hFF_FFFF);
      send(OP_EVAL, 4'hF, 32'hFFFF_FFFF, 24'hFF_FFFF);
      for (int s = 1; s < 14; s++)
         send(OP_WRITE, 4'(s), (s % 2) ? 32'h8000_0000 : 32'h0001_8000, 24'd0);
      send(OP_WRITE, 4'd14, 32'h1234_5678, 24'd0);
      send(OP_WRITE, 4'd15, 32'hFFFF_FFFF, 24'd0);
      configure(3'd7, 3'd7, 24'hFF_FFFF);
      send(OP_EVAL, 4'd0, 32'd0, 24'hFF_FFFF);
      send(OP_EVAL, 4'd0, 32'd0, 24'd0);
      send(OP_EVAL, 4'd0, 32'd0, 24'h00_8000);
      configure(3'd2, 3'd1, SCALE_RESET);
      send(OP_WRITE, 4'd7, 32'hFFFF_0000, 24'd0);
      send(OP_WRITE, 4'd0, 32'h0001_0000, 24'd0);
      send(OP_WRITE, 4'd1, 32'h0002_0000, 24'd0);
      send(OP_EVAL, 4'd0, 32'd0, 24'h01_0000);
      send(OP_WRITE, 4'd0, 32'hFFFB_0000, 24'd0);
      send(OP_EVAL, 4'd0, 32'd0, 24'h01_0000);
      send(OP_EVAL, 4'd0, 32'd0, 24'h02_0000);
      configure(3'd0, 3'd0, 24'd0);
      send(OP_EVAL, 4'd0, 32'd0, 24'h01_0000);

      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       configure(3'd7, 3'd7, SCALE_RESET);
            1:       configure(3'd1, 3'd0, 24'hFF_FFFF);
            default: configure(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                               ($urandom_range(0, 1) == 1) ? 24'($urandom)
                                                           : 24'($urandom_range(0, 24'h2_0000)));
         endcase
         for (int k = 0; k < 100; k++) random_item();
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

### sim.f
hw/rtl/rpvs_pkg.sv
hw/rtl/rpvs_mul.sv
hw/rtl/rpvs_div.sv
hw/rtl/rpvs_datapath.sv
hw/rtl/rpvs_ctrl.sv
hw/rtl/rational_polynomial_value_and_slope.sv
hw/rtl/rpvs_checker.sv
bench/rpvs_checker.sv
bench/tb.sv
